// ===== hw/rtl/sfpd_pkg.sv =====
`default_nettype none

package sfpd_pkg;

    // default frame buffer depth in bytes, start code included
    localparam int DEF_BUFFER_DEPTH = 64;

    // fixed byte codes
    localparam logic [7:0]  FILL_BYTE    = 8'hFF;
    localparam logic [7:0]  DIGIT_ZERO   = 8'h30;
    localparam logic [7:0]  DIGIT_NINE   = 8'h39;
    localparam logic [15:0] DECIMAL_BASE = 16'd10;

    // register reset values
    localparam logic [7:0] RST_FRAME_START = 8'd165;
    localparam logic [7:0] RST_FRAME_END   = 8'd90;
    localparam logic [7:0] RST_SKIP_START  = 8'd101;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FRAME_START = 2'd0;
    localparam logic [1:0] REG_FRAME_END   = 2'd1;
    localparam logic [1:0] REG_SKIP_START  = 2'd2;

    // receive mode
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_SKIP  = 2'd2
    } t_rx_mode;

    // configuration seen by the parser
    typedef struct packed {
        logic [7:0] frame_start_code;
        logic [7:0] frame_end_code;
        logic [7:0] skip_start_code;
    } t_cfg;

    // one closed frame
    typedef struct packed {
        logic [7:0]  frame_id;
        logic [15:0] number_value;
        logic        frame_kind;
        logic [5:0]  payload_len;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/sfpd_cfg_regs.sv =====
`default_nettype none

module sfpd_cfg_regs
    import sfpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [7:0] r_frame_start;
    logic [7:0] r_frame_end;
    logic [7:0] r_skip_start;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_start <= RST_FRAME_START;
            r_frame_end   <= RST_FRAME_END;
            r_skip_start  <= RST_SKIP_START;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FRAME_START: r_frame_start <= pwdata[7:0];
                REG_FRAME_END:   r_frame_end   <= pwdata[7:0];
                REG_SKIP_START:  r_skip_start  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_FRAME_START: prdata = {24'd0, r_frame_start};
            REG_FRAME_END:   prdata = {24'd0, r_frame_end};
            REG_SKIP_START:  prdata = {24'd0, r_skip_start};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg.frame_start_code = r_frame_start;
    assign o_cfg.frame_end_code   = r_frame_end;
    assign o_cfg.skip_start_code  = r_skip_start;

endmodule

`default_nettype wire

// ===== hw/rtl/sfpd_parser.sv =====
`default_nettype none

module sfpd_parser
    import sfpd_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg       i_cfg,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH);

    t_rx_mode         r_mode, n_mode;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_ff, n_ff;
    logic [7:0]       r_id, n_id;
    logic [15:0]      r_val, n_val;
    logic [CNT_W-1:0] plen;
    logic [CNT_W+5:0] plen_ext;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_cnt  <= '0;
            r_ff   <= 2'd0;
            r_id   <= 8'd0;
            r_val  <= 16'd0;
        end else begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_ff   <= n_ff;
            r_id   <= n_id;
            r_val  <= n_val;
        end
    end

    // payload length, masked to six bits
    assign plen     = r_cnt - CNT_W'(2);
    assign plen_ext = {6'd0, plen};

    // next state and result for one byte
    always_comb begin
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_ff        = r_ff;
        n_id        = r_id;
        n_val       = r_val;
        o_res_valid = 1'b0;
        o_res.frame_id     = r_id;
        o_res.number_value = 16'd0;
        o_res.frame_kind   = 1'b0;
        o_res.payload_len  = plen_ext[5:0];
        if (i_step) begin
            if (r_mode == MODE_IDLE && i_byte == i_cfg.skip_start_code) begin
                n_mode = MODE_SKIP;
                n_ff   = 2'd0;
            end else if (r_mode == MODE_SKIP) begin
                // leave after the third fill byte in a row
                if (i_byte == FILL_BYTE) begin
                    if (r_ff == 2'd2) begin
                        n_mode = MODE_IDLE;
                        n_ff   = 2'd0;
                    end else begin
                        n_ff = r_ff + 2'd1;
                    end
                end else begin
                    n_ff = 2'd0;
                end
            end else if (i_byte == FILL_BYTE) begin
                // dropped
            end else if (i_byte == i_cfg.frame_start_code) begin
                n_mode = MODE_FRAME;
                n_cnt  = CNT_W'(1);
                n_id   = 8'd0;
                n_val  = 16'd0;
            end else if (r_mode == MODE_FRAME) begin
                if (i_byte == i_cfg.frame_end_code) begin
                    n_mode = MODE_IDLE;
                    n_cnt  = '0;
                    if (r_cnt >= CNT_W'(2)) begin
                        o_res_valid = 1'b1;
                        if (plen != '0) begin
                            o_res.number_value = r_val;
                            o_res.frame_kind   = 1'b1;
                        end
                    end
                end else if (r_cnt < CNT_W'(BUFFER_DEPTH - 1)) begin
                    if (r_cnt == CNT_W'(1)) begin
                        n_id = i_byte;
                    end else if (i_byte inside {[DIGIT_ZERO:DIGIT_NINE]}) begin
                        n_val = r_val * DECIMAL_BASE + {8'd0, i_byte - DIGIT_ZERO};
                    end
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    // buffer full, frame dropped
                    n_mode = MODE_IDLE;
                    n_cnt  = '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/serial_frame_parser_decimal.sv =====
// Serial frame parser: takes one received byte per transfer and reports each
// closed frame (start code, id, payload, end code) as one result transfer with
// the id, the decimal value of the payload digits, the kind and the payload
// length. Bytes flow through an input register and then a combinational state
// update that loads the result register, so one byte is taken every cycle
// while results are taken; a result is presented from the result register once
// its end code has passed the input register and the state update. The three
// codes are set over the APB port at 0x0, 0x4 and 0x8; the user must see them
// written only while no byte is in flight, as the block does not enforce it.
`default_nettype none

module serial_frame_parser_decimal
    import sfpd_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [7:0]  o_frame_id,
    output logic      [15:0] o_number_value,
    output logic             o_frame_kind,
    output logic      [5:0]  o_payload_len
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       can_push;
    logic       step;
    logic       res_valid;
    t_result    res;

    sfpd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake between stages
    assign can_push   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && can_push;
    assign o_in_ready = !r_in_valid || can_push;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfpd_parser #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_push) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_id     = r_out.frame_id;
    assign o_number_value = r_out.number_value;
    assign o_frame_kind   = r_out.frame_kind;
    assign o_payload_len  = r_out.payload_len;

endmodule

`default_nettype wire
